// ===== rtl/ccr_pkg.sv =====
package ccr_pkg;

    // Canvas geometry and fixed-point format
    localparam int MAX_COLUMNS   = 256;
    localparam int MAX_ROWS      = 256;
    localparam int FRACTION_BITS = 8;

    // Field widths fixed by the stream format
    localparam int CMD_W     = 2;
    localparam int PIX_IDX_W = 8;
    localparam int COORD_W   = 20;
    localparam int CHAR_W    = 8;
    localparam int CFG_DIM_W = 9;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    // Stream payload packing
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = CHAR_W;
    localparam int M_TUSER_W = 1;

    // Canvas addressing: {row, column}
    localparam int COL_BITS = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_BITS = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ADDR_W   = COL_BITS + ROW_BITS;
    localparam int DEPTH    = 1 << ADDR_W;

    // Width that holds any dimension, count or read index for comparison
    localparam int COL_CNT_W = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
    localparam int DIM_A_W   = (COL_CNT_W > ROW_CNT_W) ? COL_CNT_W : ROW_CNT_W;
    localparam int DIM_B_W   = (CFG_DIM_W > PIX_IDX_W) ? CFG_DIM_W : PIX_IDX_W;
    localparam int DIM_W     = (DIM_A_W > DIM_B_W) ? DIM_A_W : DIM_B_W;

    // Distance arithmetic widths
    localparam int IDX_BITS = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;
    localparam int XF_W     = IDX_BITS + FRACTION_BITS;
    localparam int OP_W     = ((XF_W > COORD_W) ? XF_W : COORD_W) + 2;
    localparam int PROD_W   = 2 * OP_W;
    localparam int D2_W     = PROD_W + 1;

    localparam logic [COORD_W-1:0] FX_ONE = COORD_W'(1) << FRACTION_BITS;

    // Commands
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Shape type bytes
    localparam logic [CHAR_W-1:0] TYPE_OUTLINE = 8'h63;
    localparam logic [CHAR_W-1:0] TYPE_FILLED  = 8'h43;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BG     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 9'd1;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 9'd1;
    localparam logic [CHAR_W-1:0]    BG_RST     = 8'd32;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic load_radius;
        logic latch_bounds;
        logic scan_step;
        logic load_result;
    } t_ccr_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd_code;
        logic             shape_bad;
        logic             empty;
        logic             scan_last;
        logic             pipe_busy;
    } t_ccr_status;

endpackage

// ===== rtl/circle_canvas_rasterizer.sv =====
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      tuser: command; tdata: item fields
// m_axis    out  m_axis_tvalid/tready      tuser: shape_error; tdata: pixel_char
// cfg       in   i_cfg_we                  i_cfg_addr, i_cfg_wdata
//
// Clear and draw scan all W*H pixels (W, H the dimensions in use):
// the canvas memory has one write port, so the scan paints one pixel a cycle.
// Read, bad shapes and unused commands skip the scan. One item at a time.
// Reset clears control and configuration; the canvas holds garbage until cleared.
// A full output register holds a finished item in its final state; the next
// item is accepted only after that result is loaded into the output register.
module circle_canvas_rasterizer
    import ccr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // pixel_x, pixel_y, center_x, center_y,
                                                // radius, shape_type, paint_char, pad
    input  logic [S_TUSER_W-1:0] s_axis_tuser,  // command
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // pixel_char
    output logic [M_TUSER_W-1:0] m_axis_tuser,  // shape_error
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    t_ccr_cmd    cmd;
    t_ccr_status status;

    ccr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ccr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_command     (s_axis_tuser[CMD_W-1:0]),
        .i_pixel_x     (s_axis_tdata[7:0]),
        .i_pixel_y     (s_axis_tdata[15:8]),
        .i_center_x    ($signed(s_axis_tdata[35:16])),
        .i_center_y    ($signed(s_axis_tdata[55:36])),
        .i_radius      (s_axis_tdata[75:56]),
        .i_shape_type  (s_axis_tdata[83:76]),
        .i_paint_char  (s_axis_tdata[91:84]),
        .o_pixel_char  (m_axis_tdata),
        .o_shape_error (m_axis_tuser[0]),
        .i_cmd         (cmd),
        .o_status      (status)
    );

endmodule

// ===== rtl/ccr_ctrl.sv =====
module ccr_ctrl
    import ccr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    input  t_ccr_status i_status,
    output t_ccr_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SET_A  = 4'd2;
    localparam logic [3:0] S_SET_B  = 4'd3;
    localparam logic [3:0] S_SET_C  = 4'd4;
    localparam logic [3:0] S_SCAN   = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_DONE   = 4'd7;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.cmd_code)
                    CMD_CLEAR: n_state = i_status.empty ? S_DONE : S_SCAN;
                    CMD_DRAW: begin
                        if (i_status.shape_bad || i_status.empty) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SET_A;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SET_A: begin
                o_cmd.load_radius = 1'b1;
                n_state           = S_SET_B;
            end
            S_SET_B: n_state = S_SET_C;
            S_SET_C: begin
                o_cmd.latch_bounds = 1'b1;
                n_state            = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_result) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/ccr_dp.sv =====
module ccr_dp
    import ccr_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [CFG_W-1:0]           i_cfg_wdata,
    // input item fields
    input  logic [CMD_W-1:0]           i_command,
    input  logic [PIX_IDX_W-1:0]       i_pixel_x,
    input  logic [PIX_IDX_W-1:0]       i_pixel_y,
    input  logic signed [COORD_W-1:0]  i_center_x,
    input  logic signed [COORD_W-1:0]  i_center_y,
    input  logic [COORD_W-1:0]         i_radius,
    input  logic [CHAR_W-1:0]          i_shape_type,
    input  logic [CHAR_W-1:0]          i_paint_char,
    // result fields
    output logic [CHAR_W-1:0]          o_pixel_char,
    output logic                       o_shape_error,
    // control
    input  t_ccr_cmd                   i_cmd,
    output t_ccr_status                o_status
);

    // Configuration registers
    logic [CFG_DIM_W-1:0] r_width;
    logic [CFG_DIM_W-1:0] r_height;
    logic [CHAR_W-1:0]    r_bg;

    // Item registers
    logic [CMD_W-1:0]          r_cmd_code;
    logic [PIX_IDX_W-1:0]      r_px;
    logic [PIX_IDX_W-1:0]      r_py;
    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic [COORD_W-1:0]        r_rad;
    logic [CHAR_W-1:0]         r_type;
    logic [CHAR_W-1:0]         r_paint;

    // Scan counters
    logic [COL_BITS-1:0] r_x;
    logic [ROW_BITS-1:0] r_y;

    // Distance pipeline
    logic signed [OP_W-1:0] r_op_a;
    logic signed [OP_W-1:0] r_op_b;
    logic [PROD_W-1:0]      r_prod_a;
    logic [PROD_W-1:0]      r_prod_b;
    logic [D2_W-1:0]        r_d2;
    logic [PROD_W-1:0]      r_outer;
    logic [PROD_W-1:0]      r_inner;
    logic                   r_v1;
    logic                   r_v2;
    logic                   r_v3;
    logic [ADDR_W-1:0]      r_a1;
    logic [ADDR_W-1:0]      r_a2;
    logic [ADDR_W-1:0]      r_a3;

    // Canvas and read port
    logic [CHAR_W-1:0] canvas_mem [0:DEPTH-1];
    logic [CHAR_W-1:0] r_rd_data;

    // Result registers
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_err;

    logic [DIM_W-1:0]        w_use;
    logic [DIM_W-1:0]        h_use;
    logic                    x_last;
    logic                    y_last;
    logic                    read_ok;
    logic                    shape_bad;
    logic                    filled;
    logic                    is_clear;
    logic                    hit;
    logic                    wr_en;
    logic [CHAR_W-1:0]       wr_char;
    logic [ADDR_W-1:0]       rd_addr;
    logic [XF_W-1:0]         x_fx;
    logic [XF_W-1:0]         y_fx;
    logic signed [OP_W-1:0]  dx;
    logic signed [OP_W-1:0]  dy;
    logic signed [PROD_W-1:0] sq_a;
    logic signed [PROD_W-1:0] sq_b;

    // Dimensions in use, saturated to the canvas store
    assign w_use = (DIM_W'(r_width) > DIM_W'(MAX_COLUMNS)) ? DIM_W'(MAX_COLUMNS)
                                                          : DIM_W'(r_width);
    assign h_use = (DIM_W'(r_height) > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS)
                                                         : DIM_W'(r_height);

    assign x_last  = (DIM_W'(r_x) + DIM_W'(1)) == w_use;
    assign y_last  = (DIM_W'(r_y) + DIM_W'(1)) == h_use;
    assign read_ok = (DIM_W'(r_px) < w_use) && (DIM_W'(r_py) < h_use);

    assign shape_bad = ((r_type != TYPE_OUTLINE) && (r_type != TYPE_FILLED))
                       || (r_rad < FX_ONE);
    assign filled    = (r_type == TYPE_FILLED);
    assign is_clear  = (r_cmd_code == CMD_CLEAR);

    assign o_status.cmd_code  = r_cmd_code;
    assign o_status.shape_bad = shape_bad;
    assign o_status.empty     = (w_use == '0) || (h_use == '0);
    assign o_status.scan_last = x_last && y_last;
    assign o_status.pipe_busy = r_v1 || r_v2 || r_v3;

    assign o_pixel_char  = r_out_char;
    assign o_shape_error = r_out_err;

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_bg     <= BG_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_WIDTH:  r_width  <= i_cfg_wdata[CFG_DIM_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_wdata[CFG_DIM_W-1:0];
                REG_BG:     r_bg     <= i_cfg_wdata[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd_code <= i_command;
            r_px       <= i_pixel_x;
            r_py       <= i_pixel_y;
            r_cx       <= i_center_x;
            r_cy       <= i_center_y;
            r_rad      <= i_radius;
            r_type     <= i_shape_type;
            r_paint    <= i_paint_char;
        end
    end

    // Raster scan, row-major
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else if (i_cmd.accept) begin
            r_x <= '0;
            r_y <= '0;
        end else if (i_cmd.scan_step) begin
            if (x_last) begin
                r_x <= '0;
                r_y <= r_y + ROW_BITS'(1);
            end else begin
                r_x <= r_x + COL_BITS'(1);
            end
        end
    end

    // Offsets from the center in fixed point
    assign x_fx = XF_W'(r_x) << FRACTION_BITS;
    assign y_fx = XF_W'(r_y) << FRACTION_BITS;
    assign dx   = $signed({{(OP_W-XF_W){1'b0}}, x_fx})
                - $signed({{(OP_W-COORD_W){r_cx[COORD_W-1]}}, r_cx});
    assign dy   = $signed({{(OP_W-XF_W){1'b0}}, y_fx})
                - $signed({{(OP_W-COORD_W){r_cy[COORD_W-1]}}, r_cy});

    // Stage 1: multiplier operands (radius pair during setup)
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_radius) begin
            r_op_a <= $signed({{(OP_W-COORD_W){1'b0}}, r_rad});
            r_op_b <= $signed({{(OP_W-COORD_W){1'b0}}, r_rad - FX_ONE});
        end else if (i_cmd.scan_step) begin
            r_op_a <= dx;
            r_op_b <= dy;
        end
    end

    // Stage 2: squares
    assign sq_a = r_op_a * r_op_a;
    assign sq_b = r_op_b * r_op_b;

    always_ff @(posedge i_clk) begin
        r_prod_a <= $unsigned(sq_a);
        r_prod_b <= $unsigned(sq_b);
    end

    // Squared outer and inner radius, taken once per draw
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_bounds) begin
            r_outer <= r_prod_a;
            r_inner <= r_prod_b;
        end
    end

    // Stage 3: squared distance
    always_ff @(posedge i_clk) begin
        r_d2 <= D2_W'(r_prod_a) + D2_W'(r_prod_b);
    end

    // Pipeline valid and address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_step;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a1 <= {r_y, r_x};
        r_a2 <= r_a1;
        r_a3 <= r_a2;
    end

    // Stage 4: coverage test and canvas write
    assign hit = (r_d2 < D2_W'(r_outer)) && (filled || (r_d2 > D2_W'(r_inner)));
    assign wr_en   = r_v3 && (is_clear || hit);
    assign wr_char = is_clear ? r_bg : r_paint;
    assign rd_addr = {ROW_BITS'(r_py), COL_BITS'(r_px)};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            canvas_mem[r_a3] <= wr_char;
        end
        r_rd_data <= canvas_mem[rd_addr];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_out_char <= ((r_cmd_code == CMD_READ) && read_ok) ? r_rd_data : '0;
            r_out_err  <= (r_cmd_code == CMD_DRAW) && shape_bad;
        end
    end

endmodule

// ===== tb/canvas_result_checker.sv =====
module canvas_result_checker
    import ccr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream as seen at the block
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [S_TDATA_W-1:0] i_in_data,   // pixel_x, pixel_y, center_x, center_y,
                                              // radius, shape_type, paint_char, pad
    input  logic [S_TUSER_W-1:0] i_in_cmd,    // command
    // result stream as seen at the block
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [M_TDATA_W-1:0] i_out_char,  // pixel_char
    input  logic [M_TUSER_W-1:0] i_out_err,   // shape_error
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    // status toward the testbench top
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_checked
);

    typedef struct packed {
        logic [CHAR_W-1:0] pixel_char;
        logic              shape_error;
    } t_canvas_result;

    // Shadow canvas and register copies
    logic [CHAR_W-1:0]    canvas_img [0:MAX_COLUMNS*MAX_ROWS-1];
    logic [CFG_DIM_W-1:0] width_q;
    logic [CFG_DIM_W-1:0] height_q;
    logic [CHAR_W-1:0]    bg_q;
    t_canvas_result       expected_results [$];

    // Apply one command to the shadow canvas and work out its result
    task automatic predict_item(input logic [S_TUSER_W-1:0] cmd,
                                input logic [S_TDATA_W-1:0] data,
                                output t_canvas_result res);
        int                cols;
        int                rows;
        longint            cx;
        longint            cy;
        longint            rad;
        longint            one;
        longint            outer;
        longint            inner;
        longint            dx;
        longint            dy;
        longint            d2;
        logic [CHAR_W-1:0] shape;
        logic [CHAR_W-1:0] paint;
        int                px;
        int                py;

        res   = '0;
        cols  = (width_q > MAX_COLUMNS) ? MAX_COLUMNS : int'(width_q);
        rows  = (height_q > MAX_ROWS) ? MAX_ROWS : int'(height_q);
        cx    = longint'($signed(data[35:16]));
        cy    = longint'($signed(data[55:36]));
        rad   = longint'(data[75:56]);
        shape = data[83:76];
        paint = data[91:84];
        px    = int'(data[7:0]);
        py    = int'(data[15:8]);
        one   = longint'(1) << FRACTION_BITS;

        case (cmd)
            CMD_CLEAR: begin
                for (int y = 0; y < rows; y++)
                    for (int x = 0; x < cols; x++)
                        canvas_img[y*MAX_COLUMNS + x] = bg_q;
            end
            CMD_DRAW: begin
                if ((shape != TYPE_OUTLINE && shape != TYPE_FILLED) || rad < one) begin
                    res.shape_error = 1'b1;
                end else begin
                    // squared distances keep the comparison exact
                    outer = rad * rad;
                    inner = (rad - one) * (rad - one);
                    for (int y = 0; y < rows; y++) begin
                        dy = longint'(y) * one - cy;
                        for (int x = 0; x < cols; x++) begin
                            dx = longint'(x) * one - cx;
                            d2 = dx * dx + dy * dy;
                            if (d2 < outer && (shape == TYPE_FILLED || d2 > inner))
                                canvas_img[y*MAX_COLUMNS + x] = paint;
                        end
                    end
                end
            end
            CMD_READ: begin
                if (px < cols && py < rows)
                    res.pixel_char = canvas_img[py*MAX_COLUMNS + px];
            end
            default: ;
        endcase
    endtask

    // Track config, predict each input transfer, compare each output transfer
    always @(posedge i_clk) begin
        t_canvas_result exp_res;
        t_canvas_result new_res;

        if (!i_rst_n) begin
            width_q  = WIDTH_RST;
            height_q = HEIGHT_RST;
            bg_q     = BG_RST;
            expected_results.delete();
            o_mismatches = 0;
            o_checked    = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_WIDTH:  width_q  = i_cfg_wdata;
                    REG_HEIGHT: height_q = i_cfg_wdata;
                    REG_BG:     bg_q     = i_cfg_wdata[CHAR_W-1:0];
                    default: ;
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                o_checked++;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, got %02h/%0b",
                             $time, i_out_char, i_out_err);
                    o_mismatches++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_out_char !== exp_res.pixel_char) begin
                        $display("%0t: pixel_char mismatch, expected %02h, got %02h",
                                 $time, exp_res.pixel_char, i_out_char);
                        o_mismatches++;
                    end
                    if (i_out_err !== exp_res.shape_error) begin
                        $display("%0t: shape_error mismatch, expected %0b, got %0b",
                                 $time, exp_res.shape_error, i_out_err);
                        o_mismatches++;
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                predict_item(i_in_cmd, i_in_data, new_res);
                expected_results.push_back(new_res);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== tb/circle_canvas_rasterizer_tb.sv =====
module circle_canvas_rasterizer_tb;
    import ccr_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;  // unused command code
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int LONG_HOLD   = 400;
    localparam int MAX_GAP     = 12;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // pixel_x, pixel_y, center_x, center_y,
                                          // radius, shape_type, paint_char, pad
    logic [S_TUSER_W-1:0] s_axis_tuser;   // command
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // pixel_char
    logic [M_TUSER_W-1:0] m_axis_tuser;   // shape_error
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]     i_cfg_wdata;

    int          mismatch_count;
    int          results_pending;
    int          results_checked;
    int unsigned cycle_count = 0;
    int          cmd_count [4];
    int          canvas_cols;
    int          canvas_rows;
    bit          gaps_on;
    logic        hold_request;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    circle_canvas_rasterizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    canvas_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_cmd     (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_char   (m_axis_tdata),
        .i_out_err    (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_mismatches (mismatch_count),
        .o_pending    (results_pending),
        .o_checked    (results_checked)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("circle_canvas_rasterizer verification failed");
            $finish;
        end
    end

    // Result side: random stalls, calm stretches, one long hold-off
    initial begin : result_sink
        int gap;
        int taken;
        bit held;

        taken = 0;
        held  = 1'b0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request && !held) begin
                gap  = LONG_HOLD;
                held = 1'b1;
            end else if ((taken / 16) % 3 == 2) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            taken++;
        end
    end

    function automatic logic [S_TDATA_W-1:0] make_item(
        input logic [PIX_IDX_W-1:0] px,
        input logic [PIX_IDX_W-1:0] py,
        input logic [COORD_W-1:0]   cx,
        input logic [COORD_W-1:0]   cy,
        input logic [COORD_W-1:0]   rad,
        input logic [CHAR_W-1:0]    shape,
        input logic [CHAR_W-1:0]    paint
    );
        return {4'b0000, paint, shape, rad, cy, cx, py, px};
    endfunction

    // Offer one item and hold it until the transfer
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [S_TDATA_W-1:0] data);
        int gap;

        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        cmd_count[cmd]++;
    endtask

    task automatic send_clear();
        send_item(CMD_CLEAR, make_item(PIX_IDX_W'($urandom), PIX_IDX_W'($urandom),
                                       COORD_W'($urandom), COORD_W'($urandom),
                                       COORD_W'($urandom), CHAR_W'($urandom),
                                       CHAR_W'($urandom)));
    endtask

    task automatic send_none();
        send_item(CMD_NONE, make_item(PIX_IDX_W'($urandom), PIX_IDX_W'($urandom),
                                      COORD_W'($urandom), COORD_W'($urandom),
                                      COORD_W'($urandom), CHAR_W'($urandom),
                                      CHAR_W'($urandom)));
    endtask

    task automatic send_draw(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                             input logic [COORD_W-1:0] rad, input logic [CHAR_W-1:0] shape,
                             input logic [CHAR_W-1:0] paint);
        send_item(CMD_DRAW, make_item(PIX_IDX_W'($urandom), PIX_IDX_W'($urandom),
                                      cx, cy, rad, shape, paint));
    endtask

    task automatic send_read(input logic [PIX_IDX_W-1:0] px, input logic [PIX_IDX_W-1:0] py);
        send_item(CMD_READ, make_item(px, py, COORD_W'($urandom), COORD_W'($urandom),
                                      COORD_W'($urandom), CHAR_W'($urandom),
                                      CHAR_W'($urandom)));
    endtask

    // Register writes, only while the block is idle
    task automatic program_canvas(input logic [CFG_DIM_W-1:0] w,
                                  input logic [CFG_DIM_W-1:0] h,
                                  input logic [CHAR_W-1:0] bg);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_WIDTH;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_addr  <= REG_HEIGHT;
        i_cfg_wdata <= h;
        @(posedge i_clk);
        i_cfg_addr  <= REG_BG;
        i_cfg_wdata <= {1'b0, bg};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        canvas_cols = (w > MAX_COLUMNS) ? MAX_COLUMNS : int'(w);
        canvas_rows = (h > MAX_ROWS) ? MAX_ROWS : int'(h);
    endtask

    // Drop valid, wait out every expected result, then a short margin
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (results_pending != 0);
        repeat (12) @(posedge i_clk);
    endtask

    // One random command, weighted toward well-formed draws and reads
    task automatic random_item();
        int                  pick;
        int                  cx;
        int                  cy;
        int                  reach;
        int                  px;
        int                  py;
        logic [COORD_W-1:0]  rad;
        logic [CHAR_W-1:0]   shape;

        pick  = $urandom_range(0, 99);
        reach = (canvas_cols > canvas_rows) ? canvas_cols : canvas_rows;
        if (pick < 40) begin
            if ($urandom_range(0, 9) == 0) begin
                cx = $urandom;
                cy = $urandom;
            end else begin
                cx = int'($urandom_range(0, (canvas_cols + 2) * 256)) - 256;
                cy = int'($urandom_range(0, (canvas_rows + 2) * 256)) - 256;
            end
            if ($urandom_range(0, 9) == 0)
                rad = COORD_W'($urandom);
            else
                rad = COORD_W'($urandom_range(256, (reach / 2 + 2) * 256));
            shape = $urandom_range(0, 1) ? TYPE_FILLED : TYPE_OUTLINE;
            send_draw(COORD_W'(cx), COORD_W'(cy), rad, shape, CHAR_W'($urandom));
        end else if (pick < 45) begin
            // bad shape byte
            shape = CHAR_W'($urandom);
            if (shape == TYPE_OUTLINE || shape == TYPE_FILLED)
                shape ^= 8'h01;
            send_draw(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), shape,
                      CHAR_W'($urandom));
        end else if (pick < 50) begin
            // radius below one pixel
            shape = $urandom_range(0, 1) ? TYPE_FILLED : TYPE_OUTLINE;
            send_draw(COORD_W'($urandom), COORD_W'($urandom),
                      COORD_W'($urandom_range(0, 255)), shape, CHAR_W'($urandom));
        end else if (pick < 85) begin
            if (canvas_cols > 0 && $urandom_range(0, 4) != 0)
                px = $urandom_range(0, canvas_cols - 1);
            else
                px = $urandom_range(0, 255);
            if (canvas_rows > 0 && $urandom_range(0, 4) != 0)
                py = $urandom_range(0, canvas_rows - 1);
            else
                py = $urandom_range(0, 255);
            send_read(PIX_IDX_W'(px), PIX_IDX_W'(py));
        end else if (pick < 93) begin
            send_clear();
        end else begin
            send_none();
        end
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_CLEAR;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = REG_WIDTH;
        i_cfg_wdata   = '0;
        hold_request  = 1'b0;
        gaps_on       = 1'b1;
        canvas_cols   = 1;
        canvas_rows   = 1;
        foreach (cmd_count[k]) cmd_count[k] = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full canvas: first clear writes every entry before any read
        program_canvas(9'd256, 9'd256, ".");
        send_clear();
        send_read(8'd0, 8'd0);
        send_draw(20'd25600, 20'd25600, 20'd10368, TYPE_FILLED, "#");
        send_read(8'd100, 8'd100);
        send_draw(20'd51328, 20'd15424, 20'd5120, TYPE_OUTLINE, "o");
        send_read(8'd220, 8'd60);
        send_read(8'd255, 8'd255);
        send_draw(20'd25600, 20'd25600, 20'd5120, "x", "!");          // bad type
        send_draw(20'd25600, 20'd25600, 20'd255, TYPE_OUTLINE, "!");  // just under one
        send_draw(20'd25600, 20'd25600, 20'd0, TYPE_FILLED, "!");     // zero radius
        send_none();
        send_read(8'd255, 8'd0);
        wait_idle();

        // Zero width: empty canvas, nothing touched, reads give zero
        program_canvas(9'd0, 9'd5, "A");
        send_clear();
        send_draw(20'd0, 20'd0, 20'hFFFFF, TYPE_FILLED, "Z");
        send_read(8'd0, 8'd0);
        wait_idle();

        // Width above range saturates; extreme center and radius
        program_canvas(9'd511, 9'd1, 8'hFF);
        send_clear();
        send_draw(20'h80000, 20'h7FFFF, 20'hFFFFF, TYPE_FILLED, 8'h00);
        send_read(8'd255, 8'd0);
        send_read(8'd128, 8'd0);
        send_read(8'd17, 8'd1);
        wait_idle();

        // Height above range; outline of radius exactly one
        program_canvas(9'd1, 9'd300, 8'h55);
        send_clear();
        send_draw(20'd0, 20'd32640, 20'd256, TYPE_OUTLINE, "x");
        send_read(8'd0, 8'd127);
        send_read(8'd0, 8'd255);
        send_read(8'd1, 8'd0);
        wait_idle();

        // Random phases on small and full-width canvases; phase 1 backs up the result side
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: program_canvas(CFG_DIM_W'($urandom_range(1, 24)),
                                  CFG_DIM_W'($urandom_range(1, 24)), CHAR_W'($urandom));
                1: program_canvas(CFG_DIM_W'($urandom_range(2, 12)),
                                  CFG_DIM_W'($urandom_range(2, 12)), CHAR_W'($urandom));
                2: program_canvas(9'd256, CFG_DIM_W'($urandom_range(1, 2)),
                                  CHAR_W'($urandom));
                default: program_canvas(CFG_DIM_W'($urandom_range(1, 32)),
                                        CFG_DIM_W'($urandom_range(1, 8)),
                                        CHAR_W'($urandom));
            endcase
            gaps_on = (ph != 1);
            if (ph == 1)
                hold_request <= 1'b1;
            send_clear();
            repeat (24) random_item();
            wait_idle();
        end

        $display("Covered %0d clears, %0d draws, %0d reads, %0d unused commands;",
                 cmd_count[CMD_CLEAR], cmd_count[CMD_DRAW], cmd_count[CMD_READ],
                 cmd_count[CMD_NONE]);
        $display("%0d results checked across empty, saturated and small canvases.",
                 results_checked);
        if (mismatch_count == 0) begin
            $display("circle_canvas_rasterizer verification clean");
        end else begin
            $display("circle_canvas_rasterizer verification failed");
        end
        $finish;
    end

endmodule
